// ===== sv/lpd_pkg.sv =====
// Shared types and constants for the length-prefix deframer.
// No dependencies; imported by lpd_core, the top level and the testbench.
package lpd_pkg;

	localparam int unsigned HEADER_BYTES = 4;
	localparam logic [31:0] MAX_LENGTH_RESET = 32'd65536;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// one result word plus its valid flag, core to output register
	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] payload;
		logic       last;
	} result_t;

endpackage

// ===== sv/lpd_ifs.sv =====
// Valid/ready channel interfaces of the deframer: byte input, result output
// and max_length configuration write. Depends on nothing.
interface lpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface lpd_msg_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload;
	logic       last;

	modport source (output valid, output kind, output payload, output last, input ready);
	modport sink (input valid, input kind, input payload, input last, output ready);
endinterface

interface lpd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] max_length;

	modport source (output valid, output max_length, input ready);
	modport sink (input valid, input max_length, output ready);
endinterface

// ===== sv/lpd_core.sv =====
// Deframer state machine: header collection, length check, payload countdown.
// Depends on lpd_pkg. Consumes one word per step strobe, result is combinational.
module lpd_core
	import lpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic [31:0] max_length,
	output result_t     result
);

	phase_t      phase_q, phase_d;
	logic [1:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] len_q, len_d;
	logic [31:0] left_q, left_d;
	logic [31:0] shifted;
	logic [31:0] left_dec;
	logic        hdr_done;

	assign shifted  = {len_q[23:0], data_byte};
	assign left_dec = left_q - 32'd1;
	assign hdr_done = (hdr_cnt_q == 2'(HEADER_BYTES - 1));

	// next state
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		left_d    = left_q;
		case (phase_q)
			PH_HEADER: begin
				len_d = shifted;
				if (!hdr_done) begin
					hdr_cnt_d = hdr_cnt_q + 2'd1;
				end else begin
					hdr_cnt_d = 2'd0;
					if (shifted > max_length) begin
						phase_d = PH_ERROR;
						len_d   = 32'd0;
						left_d  = 32'd0;
					end else if (shifted != 32'd0) begin
						phase_d = PH_PAYLOAD;
						left_d  = shifted;
						len_d   = 32'd0;
					end
				end
			end
			PH_PAYLOAD: begin
				left_d = left_dec;
				if (left_dec == 32'd0) begin
					phase_d   = PH_HEADER;
					hdr_cnt_d = 2'd0;
					len_d     = 32'd0;
				end
			end
			default: begin
				// sticky error: drop everything
			end
		endcase
	end

	// outputs
	always_comb begin
		result = '0;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_done) begin
					if (shifted > max_length) begin
						result.valid = 1'b1;
						result.kind  = KIND_ERROR;
					end else if (shifted == 32'd0) begin
						result.valid = 1'b1;
						result.kind  = KIND_EMPTY;
						result.last  = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				result.valid   = 1'b1;
				result.kind    = KIND_BYTE;
				result.payload = data_byte;
				result.last    = (left_dec == 32'd0);
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= 2'd0;
			len_q     <= 32'd0;
			left_q    <= 32'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			len_q     <= len_d;
			left_q    <= left_d;
		end
	end

endmodule

// ===== sv/length_prefix_deframer.sv =====
// Top level of the length-prefix deframer: input register, lpd_core, output register.
// Depends on lpd_pkg, the channel interfaces in lpd_ifs.sv and lpd_core.
//
//   channel  dir  payload                  word
//   stream   in   data_byte[7:0]           one raw byte of the framed stream
//   msg      out  kind[1:0] payload[7:0]   one result: byte, empty message
//                 last                     or length error
//   cfg      in   max_length[31:0]         write of the length limit
//
// One byte per cycle sustained while msg is not stalled; the result word for a byte
// passes the input register, then the result register, on its way to msg. Header
// bytes make no result word but for the last byte of a zero or over-limit header;
// dropped bytes make none. A stalled msg holds the result register; the input
// register still takes one more byte, then stream.ready drops. Reset clears the phase
// to header collection and max_length to 65536; cfg.ready is always high.
module length_prefix_deframer
	import lpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	lpd_byte_if.sink  stream,
	lpd_msg_if.source msg,
	lpd_cfg_if.sink   cfg
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic [31:0] max_length_q;
	result_t     result;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  payload_q;
	logic        last_q;

	assign advance      = valid_s1 && (!out_valid_q || msg.ready);
	assign stream.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg.valid) begin
			max_length_q <= cfg.max_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
		end
	end

	lpd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.max_length (max_length_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || msg.ready) begin
			out_valid_q <= advance && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			kind_q    <= result.kind;
			payload_q <= result.payload;
			last_q    <= result.last;
		end
	end

	assign msg.valid   = out_valid_q;
	assign msg.kind    = kind_q;
	assign msg.payload = payload_q;
	assign msg.last    = last_q;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for length_prefix_deframer: directed and random framed byte
// streams with random stalls on both sides, checked word by word by a behavioral predictor.
// Depends on lpd_pkg, the channel interfaces in lpd_ifs.sv and the deframer RTL.
module tb_top;
	import lpd_pkg::*;

	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned QUIET_CYCLES = 6;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned BYTES_PER_PHASE = 85;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
		logic       last;
	} msg_word_t;

	logic clk;
	logic arst_n;

	lpd_byte_if stream();
	lpd_msg_if  msg();
	lpd_cfg_if  cfg();

	length_prefix_deframer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.msg    (msg),
		.cfg    (cfg)
	);

	// predictor state
	phase_t      m_phase = PH_HEADER;
	logic [1:0]  m_hdr_cnt = 2'd0;
	logic [31:0] m_len = 32'd0;
	logic [31:0] m_left = 32'd0;
	logic [31:0] m_max = MAX_LENGTH_RESET;

	msg_word_t   pending_words[$];

	// stimulus side
	logic [31:0] cur_max = MAX_LENGTH_RESET;
	bit          src_idle = 1'b0;
	bit          sink_idle = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned hold_left;
	int unsigned sink_wait;

	int unsigned fail_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned bytes_dropped = 0;
	int unsigned messages_sent = 0;
	int unsigned words_checked = 0;
	int unsigned settings_used = 0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// returns 1 when the byte produces a result word
	function automatic bit deframe_byte(input logic [7:0] b, output msg_word_t w);
		w = '{kind: KIND_BYTE, payload: 8'h00, last: 1'b0};
		case (m_phase)
			PH_HEADER: begin
				m_len = {m_len[23:0], b};
				if (32'(m_hdr_cnt) + 1 < HEADER_BYTES) begin
					m_hdr_cnt = m_hdr_cnt + 2'd1;
					return 1'b0;
				end
				m_hdr_cnt = 2'd0;
				if (m_len > m_max) begin
					m_phase = PH_ERROR;
					m_len = 32'd0;
					m_left = 32'd0;
					w.kind = KIND_ERROR;
					return 1'b1;
				end
				if (m_len == 32'd0) begin
					w.kind = KIND_EMPTY;
					w.last = 1'b1;
					return 1'b1;
				end
				m_left = m_len;
				m_len = 32'd0;
				m_phase = PH_PAYLOAD;
				return 1'b0;
			end
			PH_PAYLOAD: begin
				m_left = m_left - 32'd1;
				w.payload = b;
				if (m_left == 32'd0) begin
					m_phase = PH_HEADER;
					m_hdr_cnt = 2'd0;
					m_len = 32'd0;
					w.last = 1'b1;
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic flag_word(input string why, input msg_word_t e, input logic [1:0] k,
			input logic [7:0] p, input logic l);
		if (fail_count < 10)
			$display("%s: exp kind=%0d payload=%02h last=%0b, got kind=%0d payload=%02h last=%0b",
				why, e.kind, e.payload, e.last, k, p, l);
		fail_count++;
	endtask

	always @(posedge clk) begin : bus_monitor
		msg_word_t w;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				m_max = cfg.max_length;
			if (stream.valid && stream.ready && deframe_byte(stream.data_byte, w))
				pending_words.insert(pending_words.size(), w);
			if (msg.valid && msg.ready) begin
				words_checked++;
				if (pending_words.size() == 0) begin
					flag_word("word with none expected", '0, msg.kind, msg.payload, msg.last);
				end else begin
					w = pending_words.pop_front();
					if (msg.kind !== w.kind || msg.payload !== w.payload || msg.last !== w.last)
						flag_word("word mismatch", w, msg.kind, msg.payload, msg.last);
				end
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 40);
	endfunction

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg.ready <= 1'b0;
			hold_left <= 0;
			sink_wait <= 0;
		end else if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
			msg.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			msg.ready <= 1'b0;
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			msg.ready <= 1'b0;
		end else begin
			msg.ready <= 1'b1;
			if (sink_idle && $urandom_range(0, 99) < 20)
				sink_wait <= gap_len();
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = (src_idle && $urandom_range(0, 99) < 25) ? gap_len() : 0;
		repeat (gap) begin
			stream.valid <= 1'b0;
			@(posedge clk);
		end
		stream.valid <= 1'b1;
		stream.data_byte <= b;
		do @(posedge clk); while (!stream.ready);
		bytes_sent++;
	endtask

	task automatic send_header(input logic [31:0] len);
		send_byte(len[31:24]);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	// sender stops until every expected word is out and the pipeline has emptied
	task automatic wait_quiet();
		stream.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [31:0] v);
		cfg.valid <= 1'b1;
		cfg.max_length <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_max = v;
		settings_used++;
	endtask

	task automatic send_message(input logic [31:0] len);
		send_header(len);
		for (int unsigned i = 0; i < len; i++) begin
			// now and then the sender pauses in mid-message until all words are out
			if (i == len / 2 && len > 2 && $urandom_range(0, 99) < 5)
				wait_quiet();
			send_byte(8'($urandom_range(0, 255)));
		end
		messages_sent++;
	endtask

	function automatic int unsigned pick_length();
		int unsigned cap;
		int unsigned r;
		cap = (cur_max > 32'd200) ? 200 : int'(cur_max);
		r = $urandom_range(0, 99);
		if (cap == 0 || r < 8)
			return 0;
		if (r < 16)
			return (cap <= 40) ? cap : $urandom_range(40, cap);
		return $urandom_range(1, (cap < 24) ? cap : 24);
	endfunction

	task automatic test_short_messages();
		send_header(32'd0);
		send_header(32'd1);
		send_byte(8'h00);
		send_header(32'd2);
		send_byte(8'hFF);
		send_byte(8'hA5);
		messages_sent += 3;
		wait_quiet();
	endtask

	task automatic test_zero_max();
		write_max_length(32'd0);
		send_header(32'd0);
		messages_sent++;
		wait_quiet();
	endtask

	// a length equal to the limit is accepted
	task automatic test_length_at_max();
		write_max_length(32'd3);
		send_header(32'd3);
		send_byte(8'h5A);
		send_byte(8'hC3);
		send_byte(8'h81);
		messages_sent++;
		wait_quiet();
	endtask

	// lowering the limit under a message in progress must not cut it short
	task automatic test_cfg_mid_message();
		write_max_length(32'd8);
		send_header(32'd6);
		send_byte(8'h01);
		send_byte(8'h7E);
		send_byte(8'h80);
		wait_quiet();
		write_max_length(32'd2);
		send_byte(8'h02);
		send_byte(8'hFE);
		send_byte(8'h10);
		send_message(32'd2);
		messages_sent++;
		wait_quiet();
	endtask

	// receiver holds off while the sender keeps pushing, so the input stalls
	task automatic test_backpressure();
		write_max_length(32'hFFFF_FFFF);
		src_idle = 1'b0;
		sink_idle = 1'b0;
		hold_req = 1'b1;
		send_message(32'd60);
		wait_quiet();
	endtask

	task automatic test_random_traffic();
		logic [31:0] phase_max [RANDOM_PHASES] = '{32'd16, 32'hFFFF_FFFF, 32'd1,
			MAX_LENGTH_RESET, 32'd24, 32'hFFFF_FFFF, 32'd0, 32'd100};
		int unsigned goal;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_quiet();
			write_max_length(phase_max[ph]);
			src_idle = (ph % 3 != 2);
			sink_idle = (ph % 4 != 1);
			goal = bytes_sent + BYTES_PER_PHASE;
			while (bytes_sent < goal) begin
				send_message(pick_length());
				if ($urandom_range(0, 99) < 4)
					wait_quiet();
			end
		end
		wait_quiet();
	endtask

	// error is sticky: later bytes and a new limit do not bring the block back
	task automatic test_sticky_error();
		int unsigned before_drop;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		write_max_length(32'hFFFF_FFFE);
		send_header(32'hFFFF_FFFF);
		wait_quiet();
		before_drop = bytes_sent;
		send_header(32'd1);
		send_byte(8'hAA);
		wait_quiet();
		write_max_length(32'hFFFF_FFFF);
		send_header(32'd0);
		send_header(32'd2);
		send_byte(8'h55);
		send_byte(8'h0F);
		wait_quiet();
		bytes_dropped = bytes_sent - before_drop;
	endtask

	initial begin
		arst_n = 1'b0;
		stream.valid = 1'b0;
		stream.data_byte = 8'h00;
		cfg.valid = 1'b0;
		cfg.max_length = 32'd0;
		msg.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_messages();
		test_zero_max();
		test_length_at_max();
		test_cfg_mid_message();
		test_backpressure();
		test_random_traffic();
		test_sticky_error();

		repeat (10) @(posedge clk);
		if (pending_words.size() != 0)
			fail_count++;
		$display("sent %0d bytes in %0d messages over %0d limit settings, %0d words checked",
			bytes_sent, messages_sent, settings_used, words_checked);
		$display("sticky length error reached, %0d bytes dropped after it, %0d failures",
			bytes_dropped, fail_count);
		if (fail_count == 0)
			$display("length_prefix_deframer regression: pass");
		else
			$display("length_prefix_deframer regression: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("length_prefix_deframer regression: fail");
		$finish;
	end

endmodule
